/* src/fwrf_pkg.sv */
`timescale 1ns / 1ps
// types, constants and helpers shared by the radix formatter
// no dependencies

package fwrf_pkg;

  localparam int NUMBER_WIDTH = 32;
  localparam int CNT_W = $clog2(NUMBER_WIDTH);
  localparam int BIT_IDX_W = $clog2(NUMBER_WIDTH);

  localparam int DEC_MAX_DIGITS = 10;
  localparam int HEX_MAX_DIGITS = 8;
  localparam int BIN_MAX_DIGITS = 32;

  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_A     = 7'h41;
  localparam logic [6:0] CH_PLUS  = 7'h2B;
  localparam logic [6:0] CH_MINUS = 7'h2D;

  typedef enum logic [1:0] {
    MODE_UDEC = 2'd0,
    MODE_SDEC = 2'd1,
    MODE_HEX  = 2'd2,
    MODE_BIN  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic step;
  } dbl_ctrl_t;

  function automatic logic [6:0] digit_to_ascii(input logic [3:0] d);
    logic [6:0] dx;
    dx = {3'b000, d};
    if (d < 4'd10) begin
      return CH_ZERO + dx;
    end else begin
      return CH_A + dx - 7'd10;
    end
  endfunction

endpackage

/* src/fwrf_dabble.sv */
`timescale 1ns / 1ps
// shift and add-3 binary to bcd unit, one input bit per step
// depends on fwrf_pkg

module fwrf_dabble import fwrf_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dbl_ctrl_t               ctrl_i,
  input  logic [NUMBER_WIDTH-1:0] value_i,
  output logic [3:0]              bcd_o [DEC_MAX_DIGITS]
);

  logic [NUMBER_WIDTH-1:0] sh_q, sh_d;
  logic [3:0]              bcd_q [DEC_MAX_DIGITS];
  logic [3:0]              bcd_d [DEC_MAX_DIGITS];
  logic [3:0]              adj   [DEC_MAX_DIGITS];

  always_comb begin
    for (int k = 0; k < DEC_MAX_DIGITS; k++) begin
      adj[k] = (bcd_q[k] >= 4'd5) ? bcd_q[k] + 4'd3 : bcd_q[k];
    end
    sh_d = sh_q;
    for (int k = 0; k < DEC_MAX_DIGITS; k++) begin
      bcd_d[k] = bcd_q[k];
    end
    if (ctrl_i.load) begin
      sh_d = value_i;
      for (int k = 0; k < DEC_MAX_DIGITS; k++) begin
        bcd_d[k] = 4'd0;
      end
    end else if (ctrl_i.step) begin
      sh_d = {sh_q[NUMBER_WIDTH-2:0], 1'b0};
      // carry out of the top digit is dropped: low digits stay exact
      bcd_d[0] = {adj[0][2:0], sh_q[NUMBER_WIDTH-1]};
      for (int k = 1; k < DEC_MAX_DIGITS; k++) begin
        bcd_d[k] = {adj[k][2:0], adj[k-1][3]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sh_q <= '0;
      for (int k = 0; k < DEC_MAX_DIGITS; k++) begin
        bcd_q[k] <= 4'd0;
      end
    end else begin
      sh_q <= sh_d;
      for (int k = 0; k < DEC_MAX_DIGITS; k++) begin
        bcd_q[k] <= bcd_d[k];
      end
    end
  end

  assign bcd_o = bcd_q;

endmodule

/* src/fixed_width_radix_formatter_unit.sv */
`timescale 1ns / 1ps
// fixed-width radix formatter: number in, ascii characters out
// depends on fwrf_pkg and fwrf_dabble
//
// Usage: one transaction on the s_axis side carries a number, a mode, a digit
// count, a text line and a start column. The m_axis side then gives one
// transaction per character, most significant digit first, with tlast on the
// final character. Signed decimal puts '+' or '-' in front of the digits.
// Hex and binary modes with a nonzero count go from acceptance straight to
// emission. Decimal modes first run the shared shift/add-3 unit, one bit of the
// number per cycle, over all NUMBER_WIDTH bits before any character is formed.
// Characters then leave at one per cycle while the receiver takes them; an
// item has up to 11 characters in decimal, 8 in hex and 32 in binary.
// s_axis_tready is high only while the sequencer is idle; it rises again once
// the final character sits in the output register, even if that character
// still waits. A stalled receiver holds the output register and pauses
// emission. Reset empties the output register and returns to idle.

module fixed_width_radix_formatter_unit import fwrf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] command, [33:2] number, [39:34] digit_count,
  // [42:40] text_line, [47:43] start_column
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [6:0] character, [9:7] out_line, [15:10] out_column
  output logic [15:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  state_e state_q, state_d;

  mode_e                   mode_q, mode_d;
  logic                    neg_q, neg_d;
  logic [NUMBER_WIDTH-1:0] val_q, val_d;
  logic [5:0]              count_q, count_d;
  logic [5:0]              total_q, total_d;
  logic [2:0]              line_q, line_d;
  logic [4:0]              col_q, col_d;
  logic [5:0]              e_q, e_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;

  logic       ov_q, ov_d;
  logic [6:0] och_q, och_d;
  logic [2:0] oline_q, oline_d;
  logic [5:0] ocol_q, ocol_d;
  logic       olast_q, olast_d;

  dbl_ctrl_t  dctrl;
  logic [3:0] bcd [DEC_MAX_DIGITS];

  // input fields
  mode_e                   in_mode;
  logic [NUMBER_WIDTH-1:0] in_val;
  logic [5:0]              in_cnt;
  logic [5:0]              in_max;
  logic [5:0]              in_clamped;
  logic                    in_neg;
  logic                    in_sgn;

  logic       accept;
  logic       out_free;
  logic       sgn;
  logic [5:0] pos;
  logic [3:0] digit;
  logic [6:0] ch;
  logic       is_last;

  fwrf_dabble u_dabble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (dctrl),
    .value_i (val_d),
    .bcd_o   (bcd)
  );

  always_comb begin
    in_mode = mode_e'(s_axis_tdata[1:0]);
    in_val  = NUMBER_WIDTH'(s_axis_tdata[33:2]);
    in_cnt  = s_axis_tdata[39:34];
    unique case (in_mode)
      MODE_HEX: in_max = 6'(HEX_MAX_DIGITS);
      MODE_BIN: in_max = 6'(BIN_MAX_DIGITS);
      default:  in_max = 6'(DEC_MAX_DIGITS);
    endcase
    in_clamped = (in_cnt > in_max) ? in_max : in_cnt;
    in_sgn     = (in_mode == MODE_SDEC);
    in_neg     = in_sgn && in_val[NUMBER_WIDTH-1];
  end

  // character selection for the current emit index
  always_comb begin
    sgn     = (mode_q == MODE_SDEC);
    pos     = count_q + {5'b0, sgn} - 6'd1 - e_q;
    is_last = (e_q == total_q - 6'd1);
    unique case (mode_q)
      MODE_HEX: digit = val_q[{pos[2:0], 2'b00} +: 4];
      MODE_BIN: digit = {3'b000, val_q[pos[BIT_IDX_W-1:0]]};
      default:  digit = bcd[pos[3:0]];
    endcase
    if (sgn && (e_q == 6'd0)) begin
      ch = neg_q ? CH_MINUS : CH_PLUS;
    end else begin
      ch = digit_to_ascii(digit);
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !ov_q || m_axis_tready;

  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    neg_d   = neg_q;
    val_d   = val_q;
    count_d = count_q;
    total_d = total_q;
    line_d  = line_q;
    col_d   = col_q;
    e_d     = e_q;
    cnt_d   = cnt_q;
    ov_d    = ov_q && !m_axis_tready;
    och_d   = och_q;
    oline_d = oline_q;
    ocol_d  = ocol_q;
    olast_d = olast_q;
    dctrl   = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          mode_d  = in_mode;
          neg_d   = in_neg;
          val_d   = in_neg ? (NUMBER_WIDTH'(0) - in_val) : in_val;
          count_d = in_clamped;
          total_d = in_clamped + {5'b0, in_sgn};
          line_d  = s_axis_tdata[42:40];
          col_d   = s_axis_tdata[47:43];
          e_d     = 6'd0;
          cnt_d   = '0;
          if (in_mode == MODE_UDEC || in_mode == MODE_SDEC) begin
            dctrl.load = 1'b1;
            state_d    = ST_CONV;
          end else if (in_clamped != 6'd0) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_CONV: begin
        dctrl.step = 1'b1;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(NUMBER_WIDTH - 1)) begin
          // unsigned decimal with a zero count gives nothing
          state_d = (total_q == 6'd0) ? ST_IDLE : ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          ov_d    = 1'b1;
          och_d   = ch;
          oline_d = line_q;
          ocol_d  = {1'b0, col_q} + e_q;
          olast_d = is_last;
          e_d     = e_q + 6'd1;
          if (is_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q    <= 1'b0;
      e_q     <= 6'd0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      e_q     <= e_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q  <= mode_d;
    neg_q   <= neg_d;
    val_q   <= val_d;
    count_q <= count_d;
    total_q <= total_d;
    line_q  <= line_d;
    col_q   <= col_d;
    och_q   <= och_d;
    oline_q <= oline_d;
    ocol_q  <= ocol_d;
    olast_q <= olast_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {ocol_q, oline_q, och_q};
  assign m_axis_tlast  = olast_q;

endmodule
